/* sv/pip_pkg.sv */
// Package for the point-in-polygon test core: sizes, codes and shared types.
// Used by pip_cell, point_in_polygon_test_core and pip_checker; depends on nothing.
package pip_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int COORD_BITS   = 24;

    // Fixed field widths of the transaction and the register
    localparam int IDX_BITS = 4;
    localparam int CNT_BITS = 5;

    // Vertex select and clamped vertex count widths
    localparam int SEL_BITS = $clog2(MAX_VERTICES);
    localparam int NUM_BITS = ($clog2(MAX_VERTICES + 1) > CNT_BITS) ?
                              $clog2(MAX_VERTICES + 1) : CNT_BITS;

    localparam int MIN_VERTICES = 3;

    // Function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef logic signed [COORD_BITS-1:0]   coord_t;
    typedef logic signed [COORD_BITS:0]     diff_t;
    typedef logic signed [2*COORD_BITS+1:0] prod_t;

    // A point moving down the chain, or a vertex write into one cell
    typedef struct packed {
        logic   valid;
        coord_t x;
        coord_t y;
    } xy_t;

endpackage

/* sv/pip_cell.sv */
// One edge cell of the ray-casting chain: holds one vertex and tests one edge.
// Depends on pip_pkg for coordinate types and the point struct.
module pip_cell
    import pip_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   advance,
    input  logic   edge_en,
    input  xy_t    wr,
    input  coord_t start_x,
    input  coord_t start_y,
    input  xy_t    pt_in,
    input  logic   parity_in,
    output coord_t vtx_x,
    output coord_t vtx_y,
    output xy_t    pt_out,
    output logic   parity_out,
    output logic   parity_valid,
    output logic   busy
);

    // Stored vertex (end point of this cell's edge)
    coord_t vx_reg;
    coord_t vy_reg;

    // Stage 1: point, differences and range flags
    logic   v1_reg;
    coord_t px1_reg;
    coord_t py1_reg;
    logic   cond1_reg;
    logic   vert1_reg;
    logic   up1_reg;
    diff_t  dpx1_reg;
    diff_t  dpy1_reg;
    diff_t  dx1_reg;
    diff_t  dy1_reg;

    // Stage 2: cross products
    logic   v2_reg;
    logic   cond2_reg;
    logic   vert2_reg;
    logic   up2_reg;
    prod_t  lhs2_reg;
    prod_t  rhs2_reg;

    // Stage 3: running parity
    logic   v3_reg;
    logic   parity3_reg;

    coord_t px;
    coord_t py;
    logic   cond_next;
    logic   hit;
    logic   parity_next;

    // Capture a vertex write addressed to this cell
    always_ff @(posedge aclk) begin
        if (wr.valid) begin
            vx_reg <= wr.x;
            vy_reg <= wr.y;
        end
    end

    // Edge counts when y is in (min, max], x at most max x, edge not horizontal
    always_comb begin
        px = pt_in.x;
        py = pt_in.y;
        cond_next = edge_en && (start_y != vy_reg) &&
                    ((py > start_y) || (py > vy_reg)) &&
                    ((py <= start_y) || (py <= vy_reg)) &&
                    ((px <= start_x) || (px <= vx_reg));
    end

    // Crossing test: px - x1 against the crossing x, sign taken from dy
    always_comb begin
        if (up2_reg) begin
            hit = vert2_reg || (lhs2_reg <= rhs2_reg);
        end else begin
            hit = vert2_reg || (rhs2_reg <= lhs2_reg);
        end
        parity_next = parity_in ^ (v2_reg && cond2_reg && hit);
    end

    // Advance the valid bits of all three stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= pt_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Advance the datapath registers
    always_ff @(posedge aclk) begin
        if (advance) begin
            px1_reg     <= px;
            py1_reg     <= py;
            cond1_reg   <= cond_next;
            vert1_reg   <= (start_x == vx_reg);
            up1_reg     <= (vy_reg > start_y);
            dpx1_reg    <= diff_t'(px) - diff_t'(start_x);
            dpy1_reg    <= diff_t'(py) - diff_t'(start_y);
            dx1_reg     <= diff_t'(vx_reg) - diff_t'(start_x);
            dy1_reg     <= diff_t'(vy_reg) - diff_t'(start_y);
            cond2_reg   <= cond1_reg;
            vert2_reg   <= vert1_reg;
            up2_reg     <= up1_reg;
            lhs2_reg    <= dpx1_reg * dy1_reg;
            rhs2_reg    <= dpy1_reg * dx1_reg;
            parity3_reg <= parity_next;
        end
    end

    assign vtx_x        = vx_reg;
    assign vtx_y        = vy_reg;
    assign pt_out.valid = v1_reg;
    assign pt_out.x     = px1_reg;
    assign pt_out.y     = py1_reg;
    assign parity_out   = parity3_reg;
    assign parity_valid = v3_reg;
    assign busy         = v1_reg;

endmodule

/* sv/point_in_polygon_test_core.sv */
// Point-in-polygon test core: a chain of MAX_VERTICES edge cells, one edge each.
// Throughput: one query per cycle unless the output stalls; the point moves one cell a cycle, parity trails.
// A vertex write is taken only once no query is left reading a cell's vertex.
// Reset clears the vertex count to 0 and all valid bits; vertices stay unwritten.
module point_in_polygon_test_core
    import pip_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CNT_BITS-1:0] cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [IDX_BITS-1:0] s_vertex_index,
    input  coord_t              s_x_coord,
    input  coord_t              s_y_coord,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_inside_res,
    output logic                m_too_few_vertices
);

    logic [CNT_BITS-1:0] count_reg;
    logic                m_valid_reg;
    logic                inside_reg;
    logic                too_few_reg;

    logic [NUM_BITS-1:0] num_used;
    logic [SEL_BITS-1:0] close_sel;
    logic                too_few;
    logic                advance;
    logic                chain_empty;
    logic                last_valid;
    logic                wr_fire;
    logic                q_fire;

    xy_t    entry_pt;
    xy_t    pt_out  [MAX_VERTICES];
    logic   par     [MAX_VERTICES];
    logic   par_vld [MAX_VERTICES];
    coord_t vx_arr  [MAX_VERTICES];
    coord_t vy_arr  [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] busy_vec;

    // Hold the vertex count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_we) begin
            count_reg <= cfg_wdata;
        end
    end

    // Clamp the count to the chain length
    always_comb begin
        if (NUM_BITS'(count_reg) > NUM_BITS'(MAX_VERTICES)) begin
            num_used = NUM_BITS'(MAX_VERTICES);
        end else begin
            num_used = NUM_BITS'(count_reg);
        end
        too_few   = (num_used < NUM_BITS'(MIN_VERTICES));
        close_sel = SEL_BITS'(num_used - NUM_BITS'(1));
    end

    // Handshake: chain moves unless a finished result would collide
    assign last_valid  = par_vld[MAX_VERTICES-1];
    assign advance     = !m_valid_reg || m_ready || !last_valid;
    assign chain_empty = ~|busy_vec;
    assign s_ready     = (s_func == FUNC_QUERY) ? advance : chain_empty;
    assign wr_fire     = s_valid && s_ready && (s_func == FUNC_WRITE);
    assign q_fire      = s_valid && s_ready && (s_func == FUNC_QUERY);

    assign entry_pt.valid = q_fire;
    assign entry_pt.x     = s_x_coord;
    assign entry_pt.y     = s_y_coord;

    // Build the chain of edge cells
    for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
        xy_t    wr;
        coord_t sx;
        coord_t sy;
        xy_t    pin;
        logic   pin_par;

        assign wr.valid = wr_fire && (32'(s_vertex_index) == i);
        assign wr.x     = s_x_coord;
        assign wr.y     = s_y_coord;

        if (i == 0) begin : g_first
            // Closing edge starts at the last vertex in use
            assign sx      = vx_arr[close_sel];
            assign sy      = vy_arr[close_sel];
            assign pin     = entry_pt;
            assign pin_par = 1'b0;
        end else begin : g_next
            assign sx      = vx_arr[i-1];
            assign sy      = vy_arr[i-1];
            assign pin     = pt_out[i-1];
            assign pin_par = par[i-1];
        end

        pip_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .advance      (advance),
            .edge_en      (32'(num_used) > i),
            .wr           (wr),
            .start_x      (sx),
            .start_y      (sy),
            .pt_in        (pin),
            .parity_in    (pin_par),
            .vtx_x        (vx_arr[i]),
            .vtx_y        (vy_arr[i]),
            .pt_out       (pt_out[i]),
            .parity_out   (par[i]),
            .parity_valid (par_vld[i]),
            .busy         (busy_vec[i])
        );
    end

    // Output register: load from the last cell, drop on handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && last_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && last_valid) begin
            inside_reg  <= par[MAX_VERTICES-1] && !too_few;
            too_few_reg <= too_few;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_inside_res       = inside_reg;
    assign m_too_few_vertices = too_few_reg;

endmodule

/* sv/pip_checker.sv */
// Port-level checker for point_in_polygon_test_core, attached by bind below.
// Depends on pip_pkg for port widths.
module pip_checker
    import pip_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                s_func,
    input logic [IDX_BITS-1:0] s_vertex_index,
    input coord_t              s_x_coord,
    input coord_t              s_y_coord,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_inside_res,
    input logic                m_too_few_vertices
);

    // A stalled input transaction holds its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_func) &&
                                $stable(s_vertex_index) && $stable(s_x_coord) &&
                                $stable(s_y_coord))
        else $error("input changed while stalled");

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_inside_res) &&
                                $stable(m_too_few_vertices))
        else $error("result changed while stalled");

    // A degenerate polygon never reports inside
    a_flag_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_inside_res && m_too_few_vertices))
        else $error("inside reported with too few vertices");

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind point_in_polygon_test_core pip_checker u_pip_checker (.*);

/* sim/point_in_polygon_test_core_tb.sv */
// Self-checking testbench for point_in_polygon_test_core: vertex writes and point
// queries against a local even-odd ray-casting predictor. Depends on pip_pkg and the core.
module point_in_polygon_test_core_tb;
    import pip_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  SETTLE_CYCLES = MAX_VERTICES + 4;
    localparam int  LONG_HOLD     = 400;
    localparam int  RANDOM_PHASES = 12;
    localparam int  OPS_PER_PHASE = 50;
    localparam real TIMEOUT_NS    = 5_000_000.0;

    localparam coord_t C_MAX  = 24'sh7FFFFF;
    localparam coord_t C_MIN  = 24'sh800000;
    localparam coord_t D_SIDE = 24'sd256000;
    localparam coord_t D_HALF = 24'sd128000;

    typedef struct packed {
        logic                func;
        logic [IDX_BITS-1:0] slot;
        coord_t              x;
        coord_t              y;
    } pip_op_t;

    typedef struct packed {
        logic in_poly;
        logic too_few;
    } verdict_t;

    typedef enum {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CNT_BITS-1:0] cfg_wdata = '0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    pip_op_t             cur_op    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic                m_inside_res;
    logic                m_too_few_vertices;

    // Predictor state: vertex store and count register as the block holds them
    coord_t              held_x [MAX_VERTICES];
    coord_t              held_y [MAX_VERTICES];
    logic [CNT_BITS-1:0] held_count = '0;

    // Shape the stimulus aims at (tracks what has been written)
    coord_t shape_x [MAX_VERTICES];
    coord_t shape_y [MAX_VERTICES];

    pip_op_t  pending_ops [$];
    verdict_t expected_verdicts [$];

    int       burst_left = 0;
    int       gap_left   = 0;
    bit       sender_steady = 1'b0;
    bit       stall_request = 1'b0;
    logic     hold_off = 1'b0;
    rx_mode_t rx_mode = RX_FREE;
    logic [6:0] rx_tick = '0;

    int mismatches = 0;
    int n_writes   = 0;
    int n_verdicts = 0;
    int n_in_poly  = 0;
    int n_too_few  = 0;

    point_in_polygon_test_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (cur_op.func),
        .s_vertex_index     (cur_op.slot),
        .s_x_coord          (cur_op.x),
        .s_y_coord          (cur_op.y),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_inside_res       (m_inside_res),
        .m_too_few_vertices (m_too_few_vertices)
    );

    always #10 aclk = ~aclk;

    // Even-odd crossing count of a +x ray over the first n held vertices,
    // using exact cross-multiplication in place of the crossing-x divide
    function automatic bit ray_crossings_odd(coord_t px_in, coord_t py_in, int n);
        longint px, py, x1, y1, x2, y2, dy, y_lo, y_hi, x_top;
        bit     odd;
        bit     hit;
        px  = px_in;
        py  = py_in;
        odd = 1'b0;
        x1  = held_x[n-1];
        y1  = held_y[n-1];
        for (int i = 0; i < n; i++) begin
            x2 = held_x[i];
            y2 = held_y[i];
            dy = y2 - y1;
            // Skip horizontal edges
            if (dy != 0) begin
                y_lo  = (y1 < y2) ? y1 : y2;
                y_hi  = (y1 < y2) ? y2 : y1;
                x_top = (x1 < x2) ? x2 : x1;
                if (py > y_lo && py <= y_hi && px <= x_top) begin
                    if (x1 == x2)
                        hit = 1'b1;
                    else if (dy > 0)
                        hit = (px - x1) * dy <= (py - y1) * (x2 - x1);
                    else
                        hit = (py - y1) * (x2 - x1) <= (px - x1) * dy;
                    odd ^= hit;
                end
            end
            x1 = x2;
            y1 = y2;
        end
        return odd;
    endfunction

    // Apply one accepted transaction to the predictor
    task automatic predict_outcome(pip_op_t op);
        int       n;
        verdict_t v;
        if (op.func == FUNC_WRITE) begin
            held_x[op.slot] = op.x;
            held_y[op.slot] = op.y;
            n_writes++;
        end else begin
            n = (held_count > MAX_VERTICES) ? MAX_VERTICES : int'(held_count);
            if (n < MIN_VERTICES) begin
                v.in_poly = 1'b0;
                v.too_few = 1'b1;
            end else begin
                v.in_poly = ray_crossings_odd(op.x, op.y, n);
                v.too_few = 1'b0;
            end
            expected_verdicts = {expected_verdicts, v};
        end
    endtask

    // Driver: bursts of transactions with random gaps, payload held until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_valid && s_ready)
                predict_outcome(cur_op);
            if (s_valid && !s_ready) begin
                // hold the offered transaction
            end else if (gap_left > 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_ops.size() > 0) begin
                cur_op  <= pending_ops.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= sender_steady ? 0 : $urandom_range(0, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: receiver stall pattern plus in-order compare of each verdict
    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_tick <= '0;
            rx_mode <= RX_FREE;
        end else begin
            rx_tick <= rx_tick + 1'b1;
            if (rx_tick == '0)
                rx_mode <= rx_mode_t'($urandom_range(0, 2));
            case (rx_mode)
                RX_FREE:   m_ready <= !hold_off;
                RX_RANDOM: m_ready <= !hold_off && ($urandom_range(0, 3) != 0);
                default:   m_ready <= !hold_off && (rx_tick[2:0] < 3);
            endcase

            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: result with none expected: inside_res %0b too_few %0b",
                             $time, m_inside_res, m_too_few_vertices);
                    mismatches++;
                end else begin
                    want = expected_verdicts.pop_front();
                    n_verdicts++;
                    n_in_poly += want.in_poly;
                    n_too_few += want.too_few;
                    if (m_inside_res !== want.in_poly) begin
                        $display("%0t: inside_res mismatch: expected %0b, got %0b",
                                 $time, want.in_poly, m_inside_res);
                        mismatches++;
                    end
                    if (m_too_few_vertices !== want.too_few) begin
                        $display("%0t: too_few_vertices mismatch: expected %0b, got %0b",
                                 $time, want.too_few, m_too_few_vertices);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Long receiver hold-off so the chain fills and backs up the input
    initial begin
        wait (stall_request);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (LONG_HOLD) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    function automatic coord_t rand_coord(int span);
        return coord_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic push_op(logic func, int slot, coord_t x, coord_t y);
        pip_op_t op;
        op.func = func;
        op.slot = IDX_BITS'(slot);
        op.x    = x;
        op.y    = y;
        pending_ops = {pending_ops, op};
    endtask

    // Wait until every queued transaction is accepted and every verdict is in
    task automatic drain();
        do
            @(posedge aclk);
        while (pending_ops.size() != 0 || s_valid || expected_verdicts.size() != 0);
    endtask

    // Write the count register with the block idle, then step to a falling edge
    task automatic set_vertex_count(int value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CNT_BITS'(value);
        @(posedge aclk);
        cfg_we     <= 1'b0;
        held_count  = CNT_BITS'(value);
        @(negedge aclk);
    endtask

    // New vertex for a slot; often shares x or y with its neighbor so that
    // vertical and horizontal edges show up
    task automatic place_vertex(int slot, int span);
        int     prev;
        coord_t vx;
        coord_t vy;
        prev = (slot + MAX_VERTICES - 1) % MAX_VERTICES;
        vx   = rand_coord(span);
        vy   = rand_coord(span);
        case ($urandom_range(0, 5))
            0: vx = shape_x[prev];
            1: vy = shape_y[prev];
            2: begin
                vx = coord_t'($urandom());
                vy = coord_t'($urandom());
            end
            default: ;
        endcase
        shape_x[slot] = vx;
        shape_y[slot] = vy;
        push_op(FUNC_WRITE, slot, vx, vy);
    endtask

    // Query aimed at the interesting places of the current shape
    task automatic aim_query(int n, int span);
        int     pick;
        int     j;
        int     k;
        coord_t qx;
        coord_t qy;
        pick = $urandom_range(0, 99);
        j    = $urandom_range(0, n - 1);
        k    = (j + 1) % n;
        qx   = rand_coord(span);
        qy   = rand_coord(span);
        if (pick < 40) begin
            // random point in the shape's box
        end else if (pick < 50) begin
            qx = shape_x[j];
            qy = shape_y[j];
        end else if (pick < 65) begin
            qy = shape_y[j];
        end else if (pick < 75) begin
            qx = shape_x[j];
        end else if (pick < 90) begin
            qx = coord_t'((longint'(shape_x[j]) + longint'(shape_x[k])) >>> 1);
            qy = coord_t'((longint'(shape_y[j]) + longint'(shape_y[k])) >>> 1);
        end else begin
            qx = coord_t'($urandom());
            qy = coord_t'($urandom());
        end
        push_op(FUNC_QUERY, $urandom_range(0, 15), qx, qy);
    endtask

    // Stimulus: reset, directed phases, then random phases of shape plus queries
    initial begin
        int early_counts [6];
        int spans [4];
        int cnt;
        int span;
        int n;

        early_counts = '{16, 3, 31, 17, 1, 9};
        spans        = '{64, 4096, 1 << 20, 8388607};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty polygon, extreme coordinates
        set_vertex_count(0);
        push_op(FUNC_QUERY, 15, C_MAX, C_MIN);

        // Square on the extremes of the coordinate range, then a diamond
        // with slanted edges and points exactly on them
        set_vertex_count(4);
        push_op(FUNC_WRITE, 0, C_MIN, C_MIN);
        push_op(FUNC_WRITE, 1, C_MAX, C_MIN);
        push_op(FUNC_WRITE, 2, C_MAX, C_MAX);
        push_op(FUNC_WRITE, 3, C_MIN, C_MAX);
        push_op(FUNC_QUERY, 0, 24'sd0, 24'sd0);
        push_op(FUNC_QUERY, 1, C_MAX, 24'sd0);
        push_op(FUNC_QUERY, 2, C_MIN, 24'sd0);
        push_op(FUNC_QUERY, 4, 24'sd0, C_MIN);
        push_op(FUNC_QUERY, 8, 24'sd0, C_MAX);
        push_op(FUNC_WRITE, 0, 24'sd0, -D_SIDE);
        push_op(FUNC_WRITE, 1, D_SIDE, 24'sd0);
        push_op(FUNC_WRITE, 2, 24'sd0, D_SIDE);
        push_op(FUNC_WRITE, 3, -D_SIDE, 24'sd0);
        push_op(FUNC_QUERY, 0, D_HALF, -D_HALF);
        push_op(FUNC_QUERY, 0, D_HALF + 24'sd1, -D_HALF);
        push_op(FUNC_QUERY, 0, -D_HALF, D_HALF);
        push_op(FUNC_QUERY, 0, D_SIDE, 24'sd0);

        // Two vertices only
        set_vertex_count(2);
        push_op(FUNC_QUERY, 0, 24'sd0, 24'sd0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            cnt = (phase < 6) ? early_counts[phase] : $urandom_range(0, 31);
            set_vertex_count(cnt);
            span          = spans[$urandom_range(0, 3)];
            sender_steady = (phase == 2) || ($urandom_range(0, 3) == 0);
            n = (cnt > MAX_VERTICES) ? MAX_VERTICES : cnt;
            if (n < MIN_VERTICES)
                n = MAX_VERTICES;

            for (int slot = 0; slot < MAX_VERTICES; slot++)
                place_vertex(slot, span);
            for (int op_i = 0; op_i < OPS_PER_PHASE; op_i++) begin
                if ($urandom_range(0, 99) < 8)
                    place_vertex($urandom_range(0, MAX_VERTICES - 1), span);
                else
                    aim_query(n, span);
            end

            // Back up the chain while this phase streams without gaps
            if (phase == 2)
                stall_request = 1'b1;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Checked %0d query verdicts (%0d inside, %0d too few vertices)",
                 n_verdicts, n_in_poly, n_too_few);
        $display("and %0d vertex writes over %0d vertex-count settings.",
                 n_writes, RANDOM_PHASES + 3);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
